// ===== hdl/fwrl_pkg.sv =====
// Shared types, widths and codes of the fixed-window rate limiter.
package fwrl_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 16;
  localparam int unsigned TYPE_W         = 3;
  localparam int unsigned SLOT_W         = 4;
  localparam int unsigned TICK_W         = 32;
  localparam int unsigned REQ_W          = 16;
  localparam int unsigned TOK_W          = 32;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic              ENABLE_RESET = 1'b1;
  localparam logic [TICK_W-1:0] WINDOW_RESET = TICK_W'(60000);
  localparam logic [REQ_W-1:0]  REQ_MAX      = '1;
  localparam logic [TOK_W-1:0]  TOK_MAX      = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_CHECK      = 3'd1,
    KIND_RECORD     = 3'd2,
    KIND_CONFIG     = 3'd3,
    KIND_RESET_SLOT = 3'd4,
    KIND_RESET_ALL  = 3'd5,
    KIND_NOP        = 3'd6
  } fwrl_kind_e;

  typedef struct packed {
    fwrl_kind_e         kind;
    logic               in_range;
    logic [SLOT_W-1:0]  slot;
    logic [TOK_W-1:0]   token_amount;
    logic [REQ_W-1:0]   request_limit;
    logic [TOK_W-1:0]   token_limit;
  } fwrl_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0]  request_limit;
    logic [TOK_W-1:0]  token_limit;
    logic [REQ_W-1:0]  request_count;
    logic [TOK_W-1:0]  token_count;
    logic [TICK_W-1:0] window_start;
  } fwrl_slot_t;

  localparam int unsigned SLOT_REC_W = $bits(fwrl_slot_t);

  typedef struct packed {
    logic pop;
    logic exec;
    logic done;
    logic load;
  } fwrl_bstat_t;

endpackage

// ===== hdl/fwrl_if.sv =====
// Request and response channel interfaces of the rate limiter.
interface fwrl_req_if import fwrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TYPE_W-1:0]    req_type;
  logic [SLOT_W-1:0]    slot;
  logic [TOK_W-1:0]     token_amount;
  logic [REQ_W-1:0]     request_limit;
  logic [TOK_W-1:0]     token_limit;

  modport source (output valid, req_type, slot, token_amount, request_limit, token_limit,
                  input ready);
  modport sink   (input valid, req_type, slot, token_amount, request_limit, token_limit,
                  output ready);
endinterface

interface fwrl_rsp_if import fwrl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 allowed;
  logic [TICK_W-1:0]    wait_ticks;
  logic [REQ_W-1:0]     request_count;
  logic [TOK_W-1:0]     token_count;
  logic                 slot_configured;

  modport source (output valid, allowed, wait_ticks, request_count, token_count,
                  slot_configured, input ready);
  modport sink   (input valid, allowed, wait_ticks, request_count, token_count,
                  slot_configured, output ready);
endinterface

// ===== hdl/fwrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fwrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/fwrl_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
module fwrl_front import fwrl_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwrl_req_if.sink    req_i,
  input  logic        pop_i,
  output logic        cmd_valid_o,
  output fwrl_cmd_t   cmd_o
);

  fwrl_cmd_t   entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  fwrl_cmd_t   cmd_new;
  logic        push;

  always_comb begin
    case (req_i.req_type)
      KIND_TICK:       cmd_new.kind = KIND_TICK;
      KIND_CHECK:      cmd_new.kind = KIND_CHECK;
      KIND_RECORD:     cmd_new.kind = KIND_RECORD;
      KIND_CONFIG:     cmd_new.kind = KIND_CONFIG;
      KIND_RESET_SLOT: cmd_new.kind = KIND_RESET_SLOT;
      KIND_RESET_ALL:  cmd_new.kind = KIND_RESET_ALL;
      default:         cmd_new.kind = KIND_NOP;
    endcase
    cmd_new.in_range      = (32'(req_i.slot) < 32'(SLOT_COUNT));
    cmd_new.slot          = req_i.slot;
    cmd_new.token_amount  = req_i.token_amount;
    cmd_new.request_limit = req_i.request_limit;
    cmd_new.token_limit   = req_i.token_limit;
  end

  assign req_i.ready = (count_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/fwrl_back.sv =====
// Back end: reads the addressed slot, updates it and forms the result.
module fwrl_back import fwrl_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enable_i,
  input  logic [TICK_W-1:0]  window_i,
  input  logic               cmd_valid_i,
  input  fwrl_cmd_t          cmd_i,
  output logic               pop_o,
  fwrl_rsp_if.source         rsp_o,
  output fwrl_bstat_t        stat_o
);

  localparam int unsigned IW = $clog2(SLOT_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_e;

  state_e             state_q;
  fwrl_cmd_t          cmd_q;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [TICK_W-1:0]  ra_tick_q, ra_tick_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [SLOT_COUNT-1:0] stale_q, stale_d;
  fwrl_slot_t         res_q, nxt;
  logic               ok_q, ok_n;
  logic               allowed_q, allowed_n;

  logic               out_valid_q;
  logic               out_allowed_q;
  logic [TICK_W-1:0]  out_wait_q;
  logic [REQ_W-1:0]   out_req_cnt_q;
  logic [TOK_W-1:0]   out_tok_cnt_q;
  logic               out_conf_q;

  logic [IW-1:0]      raddr;
  logic [IW-1:0]      idx;
  logic [SLOT_REC_W-1:0] rdata;
  fwrl_slot_t         cur, restart;
  logic               slot_ok;
  logic [TICK_W-1:0]  elapsed;
  logic               expired;
  logic [TOK_W:0]     tok_sum;
  logic               we;

  logic [TICK_W-1:0]  elapsed_res;
  logic               live;
  logic [TICK_W-1:0]  wait_val;
  logic               load;

  assign pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign raddr = cmd_i.in_range ? IW'(cmd_i.slot) : '0;
  assign idx   = cmd_q.in_range ? IW'(cmd_q.slot) : '0;

  fwrl_ram #(
    .WIDTH (SLOT_REC_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx),
    .wdata_i (nxt),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A slot marked stale has been cleared by a reset-all and not written since.
  always_comb begin
    cur = fwrl_slot_t'(rdata);
    if (stale_q[idx]) begin
      cur.request_count = '0;
      cur.token_count   = '0;
      cur.window_start  = ra_tick_q;
    end
    restart               = cur;
    restart.request_count = '0;
    restart.token_count   = '0;
    restart.window_start  = tick_q;
    slot_ok = cmd_q.in_range && valid_q[idx];
    elapsed = tick_q - cur.window_start;
    expired = (elapsed >= window_i);
    tok_sum = {1'b0, cur.token_count} + {1'b0, cmd_q.token_amount};
  end

  always_comb begin
    nxt       = cur;
    we        = 1'b0;
    ok_n      = slot_ok;
    allowed_n = 1'b0;
    tick_d    = tick_q;
    ra_tick_d = ra_tick_q;
    valid_d   = valid_q;
    stale_d   = stale_q;
    if (state_q == ST_EXEC) begin
      case (cmd_q.kind)
        KIND_TICK: begin
          tick_d = tick_q + TICK_W'(1);
        end
        KIND_CHECK: begin
          allowed_n = 1'b1;
          if (enable_i && slot_ok && !expired) begin
            if (cur.request_count >= cur.request_limit) begin
              allowed_n = 1'b0;
            end else if ((cur.token_limit != '0) && (cmd_q.token_amount != '0) &&
                         (tok_sum > {1'b0, cur.token_limit})) begin
              allowed_n = 1'b0;
            end
          end
        end
        KIND_RECORD: begin
          if (enable_i && slot_ok) begin
            we = 1'b1;
            if (expired) begin
              nxt.window_start  = tick_q;
              nxt.request_count = REQ_W'(1);
              nxt.token_count   = cmd_q.token_amount;
            end else begin
              if (cur.request_count != REQ_MAX) begin
                nxt.request_count = cur.request_count + REQ_W'(1);
              end
              nxt.token_count = tok_sum[TOK_W] ? TOK_MAX : tok_sum[TOK_W-1:0];
            end
          end
        end
        KIND_CONFIG: begin
          if (cmd_q.in_range) begin
            we                = 1'b1;
            ok_n              = 1'b1;
            valid_d[idx]      = 1'b1;
            nxt.request_limit = cmd_q.request_limit;
            nxt.token_limit   = cmd_q.token_limit;
            nxt.request_count = '0;
            nxt.token_count   = '0;
            nxt.window_start  = tick_q;
          end
        end
        KIND_RESET_SLOT: begin
          if (slot_ok) begin
            we  = 1'b1;
            nxt = restart;
          end
        end
        KIND_RESET_ALL: begin
          ra_tick_d = tick_q;
          stale_d   = '1;
          if (slot_ok) begin
            nxt = restart;
          end
        end
        default: begin
        end
      endcase
      if (we) begin
        stale_d[idx] = 1'b0;
      end
    end
  end

  // Result of the finished item, taken from the updated slot record.
  always_comb begin
    elapsed_res = tick_q - res_q.window_start;
    live        = ok_q && enable_i && (elapsed_res < window_i);
    wait_val    = live ? (window_i - elapsed_res) : '0;
    load        = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cmd_q         <= '0;
      tick_q        <= '0;
      ra_tick_q     <= '0;
      valid_q       <= '0;
      stale_q       <= '0;
      res_q         <= '0;
      ok_q          <= 1'b0;
      allowed_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_allowed_q <= 1'b0;
      out_wait_q    <= '0;
      out_req_cnt_q <= '0;
      out_tok_cnt_q <= '0;
      out_conf_q    <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      ra_tick_q <= ra_tick_d;
      valid_q   <= valid_d;
      stale_q   <= stale_d;
      if (rsp_o.ready && !load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_q     <= nxt;
          ok_q      <= ok_n;
          allowed_q <= allowed_n;
          state_q   <= ST_DONE;
        end
        ST_DONE: begin
          if (load) begin
            out_valid_q   <= 1'b1;
            out_allowed_q <= allowed_q;
            out_wait_q    <= wait_val;
            out_req_cnt_q <= ok_q ? res_q.request_count : '0;
            out_tok_cnt_q <= ok_q ? res_q.token_count : '0;
            out_conf_q    <= ok_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.allowed         = out_allowed_q;
  assign rsp_o.wait_ticks      = out_wait_q;
  assign rsp_o.request_count   = out_req_cnt_q;
  assign rsp_o.token_count     = out_tok_cnt_q;
  assign rsp_o.slot_configured = out_conf_q;

  assign stat_o.pop  = pop_o;
  assign stat_o.exec = (state_q == ST_EXEC);
  assign stat_o.done = (state_q == ST_DONE);
  assign stat_o.load = load;

endmodule

// ===== hdl/fixed_window_rate_limiter_top.sv =====
// Top level of the fixed-window rate limiter: configuration registers and both halves.
//
//   channel   direction  transfer when           payload
//   req_i     in         req_i.valid & ready     req_type, slot, token_amount, limits
//   rsp_o     out        rsp_o.valid & ready     allowed, wait_ticks, counters, configured
//   cfg       in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// Each item passes through the back end's slot read, update and result steps, and the
// back end takes no new item until the result of the last one is loaded; the registered
// read port of the slot RAM and the read-modify-write of one slot set this. An accepted
// item waits in the queue, and its response is registered on the output.
// After reset all slots are unconfigured at once; there is no clearing pass.
// The two-entry queue takes up to two items while the back end or the output stalls.
module fixed_window_rate_limiter_top import fwrl_pkg::*; #(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fwrl_req_if.sink              req_i,
  fwrl_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic               enable_q;
  logic [TICK_W-1:0]  window_q;
  logic               pop;
  logic               cmd_valid;
  fwrl_cmd_t          cmd;
  fwrl_bstat_t        stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= ENABLE_RESET;
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE: enable_q <= cfg_wdata_i[0];
        REG_WINDOW: window_q <= cfg_wdata_i[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fwrl_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .pop_i       (pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  fwrl_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .window_i    (window_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .rsp_o       (rsp_o),
    .stat_o      (stat)
  );

  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop |=> stat.exec)
    else $error("popped item did not enter the update step");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.exec |=> stat.done)
    else $error("update step not followed by result step");

  a_steps_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({stat.pop, stat.exec, stat.done}))
    else $error("back end in more than one step at once");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.load |=> rsp_o.valid)
    else $error("loaded result not presented on the output");

endmodule

// ===== bench/fwrl_limit_checker.sv =====
// Response checker for the rate limiter: predicts each response and compares it.
`timescale 1ns / 100ps
module fwrl_limit_checker import fwrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fwrl_req_if                   req_mon,
  fwrl_rsp_if                   rsp_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o,
  output int unsigned           matched_o
);

  localparam int unsigned SLOTS = SLOT_COUNT_DEF;

  typedef struct packed {
    logic              allowed;
    logic [TICK_W-1:0] wait_ticks;
    logic [REQ_W-1:0]  request_count;
    logic [TOK_W-1:0]  token_count;
    logic              slot_configured;
  } limiter_rsp_t;

  logic              limit_on;
  logic [TICK_W-1:0] window_len;
  logic [TICK_W-1:0] tick_now;
  logic              slot_live [SLOTS];
  logic [REQ_W-1:0]  req_cap   [SLOTS];
  logic [REQ_W-1:0]  req_used  [SLOTS];
  logic [TOK_W-1:0]  tok_cap   [SLOTS];
  logic [TOK_W-1:0]  tok_used  [SLOTS];
  logic [TICK_W-1:0] win_base  [SLOTS];

  limiter_rsp_t due_rsp [$];
  int unsigned  err_cnt;
  int unsigned  match_cnt;

  initial begin
    err_cnt   = 0;
    match_cnt = 0;
    pending_o = 0;
    errors_o  = 0;
    matched_o = 0;
  end

  function automatic void clear_limiter();
    limit_on   = ENABLE_RESET;
    window_len = WINDOW_RESET;
    tick_now   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      req_cap[i]   = '0;
      req_used[i]  = '0;
      tok_cap[i]   = '0;
      tok_used[i]  = '0;
      win_base[i]  = '0;
    end
  endfunction

  // Elapsed time wraps modulo 2^32, exactly as the tick clock does.
  function automatic logic [TICK_W-1:0] elapsed_in(input int unsigned s);
    return tick_now - win_base[s];
  endfunction

  function automatic logic window_over(input int unsigned s);
    return elapsed_in(s) >= window_len;
  endfunction

  function automatic void restart_window(input int unsigned s);
    req_used[s] = '0;
    tok_used[s] = '0;
    win_base[s] = tick_now;
  endfunction

  // Applies one request to the slot table and returns the response it should give.
  function automatic limiter_rsp_t apply_request(input logic [TYPE_W-1:0] kind,
                                                 input logic [SLOT_W-1:0] slot,
                                                 input logic [TOK_W-1:0]  amount,
                                                 input logic [REQ_W-1:0]  rlim,
                                                 input logic [TOK_W-1:0]  tlim);
    limiter_rsp_t rsp;
    logic [TOK_W:0] sum;
    int unsigned s;
    s   = 32'(slot);
    rsp = '0;
    case (kind)
      KIND_TICK: begin
        tick_now = tick_now + 1'b1;
      end
      KIND_CHECK: begin
        rsp.allowed = 1'b1;
        if (limit_on && slot_live[s] && !window_over(s)) begin
          sum = {1'b0, tok_used[s]} + {1'b0, amount};
          if (req_used[s] >= req_cap[s]) begin
            rsp.allowed = 1'b0;
          end else if (tok_cap[s] != '0 && amount != '0 && sum > {1'b0, tok_cap[s]}) begin
            rsp.allowed = 1'b0;
          end
        end
      end
      KIND_RECORD: begin
        if (limit_on && slot_live[s]) begin
          if (window_over(s)) begin
            restart_window(s);
          end
          if (req_used[s] != REQ_MAX) begin
            req_used[s] = req_used[s] + 1'b1;
          end
          sum = {1'b0, tok_used[s]} + {1'b0, amount};
          tok_used[s] = sum[TOK_W] ? TOK_MAX : sum[TOK_W-1:0];
        end
      end
      KIND_CONFIG: begin
        slot_live[s] = 1'b1;
        req_cap[s]   = rlim;
        tok_cap[s]   = tlim;
        restart_window(s);
      end
      KIND_RESET_SLOT: begin
        if (slot_live[s]) begin
          restart_window(s);
        end
      end
      KIND_RESET_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            restart_window(i);
          end
        end
      end
      default: begin
      end
    endcase
    if (slot_live[s]) begin
      if (limit_on && !window_over(s)) begin
        rsp.wait_ticks = window_len - elapsed_in(s);
      end
      rsp.request_count   = req_used[s];
      rsp.token_count     = tok_used[s];
      rsp.slot_configured = 1'b1;
    end
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    limiter_rsp_t seen;
    limiter_rsp_t want;
    if (!rst_ni) begin
      clear_limiter();
      due_rsp.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE: limit_on = cfg_wdata_i[0];
          REG_WINDOW: window_len = cfg_wdata_i[TICK_W-1:0];
          default: begin
          end
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.allowed         = rsp_mon.allowed;
        seen.wait_ticks      = rsp_mon.wait_ticks;
        seen.request_count   = rsp_mon.request_count;
        seen.token_count     = rsp_mon.token_count;
        seen.slot_configured = rsp_mon.slot_configured;
        if (due_rsp.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("%0t: response transfer with nothing outstanding: allowed=%0b wait=%0d",
                     $realtime, seen.allowed, seen.wait_ticks);
          end
        end else begin
          want = due_rsp.pop_front();
          if (seen.allowed !== want.allowed || seen.wait_ticks !== want.wait_ticks ||
              seen.request_count !== want.request_count ||
              seen.token_count !== want.token_count ||
              seen.slot_configured !== want.slot_configured) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: expected allowed=%0b wait=%0d reqs=%0d tokens=%0d cfg=%0b",
                       $realtime, want.allowed, want.wait_ticks, want.request_count,
                       want.token_count, want.slot_configured);
              $display("%0t:      got allowed=%0b wait=%0d reqs=%0d tokens=%0d cfg=%0b",
                       $realtime, seen.allowed, seen.wait_ticks, seen.request_count,
                       seen.token_count, seen.slot_configured);
            end
          end else begin
            match_cnt++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        due_rsp.push_back(apply_request(req_mon.req_type, req_mon.slot, req_mon.token_amount,
                                        req_mon.request_limit, req_mon.token_limit));
      end
    end
    pending_o <= due_rsp.size();
    errors_o  <= err_cnt;
    matched_o <= match_cnt;
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the rate limiter: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps
module tb_top;
  import fwrl_pkg::*;

  localparam logic [TYPE_W-1:0] KIND_SPARE  = 3'd7;
  localparam int unsigned       PHASES      = 7;
  localparam int unsigned       PHASE_ITEMS = 200;
  localparam int unsigned       TAIL_CYCLES = 12;
  localparam int unsigned       CYCLE_LIMIT = 2_000_000;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  gaps_on;
  int unsigned           stall_left;
  int unsigned           cycle_cnt;
  int unsigned           items_sent;
  int unsigned           settings_used;
  int unsigned           pending;
  int unsigned           errors;
  int unsigned           matched;
  logic [CFG_DATA_W-1:0] phase_window [PHASES];
  logic                  phase_enable [PHASES];

  fwrl_req_if req_ch ();
  fwrl_rsp_if rsp_ch ();

  fixed_window_rate_limiter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  fwrl_limit_checker rsp_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (pending),
    .errors_o    (errors),
    .matched_o   (matched)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The response side drops ready in random bursts while gaps are on.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic drive_req(input logic [TYPE_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                           input logic [TOK_W-1:0] amount, input logic [REQ_W-1:0] rlim,
                           input logic [TOK_W-1:0] tlim);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.slot          <= slot;
    req_ch.token_amount  <= amount;
    req_ch.request_limit <= rlim;
    req_ch.token_limit   <= tlim;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stops sending and waits until every outstanding response has come back.
  task automatic settle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  task automatic random_req();
    logic [TYPE_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [TOK_W-1:0]  amount;
    logic [REQ_W-1:0]  rlim;
    logic [TOK_W-1:0]  tlim;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = KIND_TICK;
    else if (pick < 55) kind = KIND_CHECK;
    else if (pick < 78) kind = KIND_RECORD;
    else if (pick < 88) kind = KIND_CONFIG;
    else if (pick < 94) kind = KIND_RESET_SLOT;
    else if (pick < 96) kind = KIND_RESET_ALL;
    else if (pick < 98) kind = KIND_NOP;
    else                kind = KIND_SPARE;
    // Most traffic goes to a few slots so that their windows and counters build up.
    slot = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, 3)) : SLOT_W'($urandom);
    case ($urandom_range(0, 9))
      0:       amount = '0;
      1:       amount = $urandom;
      2:       amount = TOK_MAX - $urandom_range(0, 255);
      default: amount = $urandom_range(0, 40);
    endcase
    case ($urandom_range(0, 7))
      0:       rlim = REQ_W'($urandom);
      1:       rlim = '0;
      default: rlim = REQ_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 4))
      0:       tlim = '0;
      1:       tlim = $urandom;
      default: tlim = $urandom_range(20, 150);
    endcase
    drive_req(kind, slot, amount, rlim, tlim);
  endtask

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = KIND_TICK;
    req_ch.slot          = '0;
    req_ch.token_amount  = '0;
    req_ch.request_limit = '0;
    req_ch.token_limit   = '0;
    rsp_ch.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_ENABLE;
    cfg_wdata            = '0;
    gaps_on              = 1'b1;
    stall_left           = 0;
    cycle_cnt            = 0;
    items_sent           = 0;
    settings_used        = 0;
    phase_window = '{32'd20, 32'd1, 32'd5, 32'd60000, 32'hFFFF_FFFF, 32'd12, 32'd40};
    phase_enable = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: unconfigured slots, then request and token limits tripping.
    drive_req(KIND_CHECK, 4'd3, 32'd5, '0, '0);
    drive_req(KIND_RECORD, 4'd3, 32'd5, '0, '0);
    drive_req(KIND_RESET_SLOT, 4'd3, '0, '0, '0);
    drive_req(KIND_CONFIG, 4'd0, '0, 16'd2, 32'd100);
    drive_req(KIND_CHECK, 4'd0, 32'd60, '0, '0);
    drive_req(KIND_RECORD, 4'd0, 32'd60, '0, '0);
    drive_req(KIND_CHECK, 4'd0, 32'd41, '0, '0);
    drive_req(KIND_CHECK, 4'd0, 32'd0, '0, '0);
    drive_req(KIND_RECORD, 4'd0, 32'd0, '0, '0);
    drive_req(KIND_CHECK, 4'd0, 32'd1, '0, '0);
    drive_req(KIND_CONFIG, 4'd15, '0, '0, '0);
    drive_req(KIND_CHECK, 4'd15, TOK_MAX, '0, '0);
    drive_req(KIND_CONFIG, 4'd1, '0, REQ_MAX, TOK_MAX);
    drive_req(KIND_RECORD, 4'd1, TOK_MAX, '0, '0);
    drive_req(KIND_RECORD, 4'd1, 32'd1, '0, '0);
    drive_req(KIND_CHECK, 4'd1, 32'd1, '0, '0);
    drive_req(KIND_TICK, 4'hF, TOK_MAX, REQ_MAX, TOK_MAX);
    drive_req(KIND_NOP, 4'd0, '0, '0, '0);
    drive_req(KIND_SPARE, 4'd1, '0, '0, '0);
    drive_req(KIND_RESET_SLOT, 4'd0, '0, '0, '0);
    drive_req(KIND_RESET_ALL, 4'd0, '0, '0, '0);

    // A short window: it runs down with ticks, expires, and a record restarts it.
    settle();
    write_reg(REG_WINDOW, 32'd3);
    drive_req(KIND_CONFIG, 4'd2, '0, 16'd5, '0);
    drive_req(KIND_TICK, 4'd2, '0, '0, '0);
    drive_req(KIND_TICK, 4'd2, '0, '0, '0);
    drive_req(KIND_TICK, 4'd2, '0, '0, '0);
    drive_req(KIND_CHECK, 4'd2, TOK_MAX, '0, '0);
    drive_req(KIND_RECORD, 4'd2, 32'd9, '0, '0);

    settle();
    write_reg(REG_ENABLE, 32'd0);
    drive_req(KIND_CHECK, 4'd15, 32'd1, '0, '0);
    drive_req(KIND_RECORD, 4'd2, 32'd1, '0, '0);

    // A zero-length window leaves every slot expired.
    settle();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_WINDOW, '0);
    drive_req(KIND_CHECK, 4'd15, 32'd1, '0, '0);
    drive_req(KIND_RECORD, 4'd2, 32'd1, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_ENABLE, CFG_DATA_W'(phase_enable[p]));
      write_reg(REG_WINDOW, phase_window[p]);
      gaps_on = (p != 3) && (p != PHASES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          settle();
        end
        random_req();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests, %0d responses matched, over %0d register writes.",
             items_sent, matched, settings_used);
    $display("Included short, zero and maximum windows, a disabled phase and a saturated counter.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/fwrl_pkg.sv
hdl/fwrl_if.sv
hdl/fwrl_ram.sv
hdl/fwrl_front.sv
hdl/fwrl_back.sv
hdl/fixed_window_rate_limiter_top.sv
bench/fwrl_limit_checker.sv
bench/tb_top.sv
